// File: src/graph_bfs_dfs_traversal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the graph traversal block.
// Concurrent checks with a same-cycle or next-cycle consequent.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// Types and constants shared by the graph traversal block and its channels.
// ----------------------------------------------------------------------------
package gbt_pkg;

    localparam int VERTEX_W = 5;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 2;
    localparam int VCOUNT_W = 6;
    // Wide enough for the vertex count register and any vertex limit.
    localparam int LIMIT_W  = 7;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_DEGREE   = 32;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BFS   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DFS   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VISIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
        logic [VERTEX_W-1:0] start_vertex;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_A,
        ST_E_B,
        ST_E_W1,
        ST_E_W2,
        ST_B_POP,
        ST_B_CUR,
        ST_B_NRD,
        ST_B_NCHK,
        ST_D_TOP,
        ST_D_GOT,
        ST_D_CHK,
        ST_END
    } t_state;

endpackage

// File: src/gbt_if.sv
// ----------------------------------------------------------------------------
// gbt_in_if / gbt_out_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
interface gbt_in_if;
    logic              valid;
    logic              ready;
    gbt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbt_out_if;
    logic               valid;
    logic               ready;
    gbt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/graph_bfs_dfs_traversal.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// Clear and add-edge each give one result beat; add-edge runs ST_E_A to ST_E_W2.
// A breadth-first walk runs ST_B_POP and ST_B_CUR per vertex and ST_B_NRD and
// ST_B_NCHK per neighbor entry read; a depth-first walk runs ST_D_TOP, ST_D_GOT
// and ST_D_CHK per entry; both are bounded by the neighbor memory's single read port.
// One command is worked at a time; results leave through an output register.
// Synchronous active-low reset clears counts, marks and control; no sweep.
// ----------------------------------------------------------------------------
`include "graph_bfs_dfs_traversal_assert.svh"

module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES = gbt_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = gbt_pkg::DEF_MAX_DEGREE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbt_pkg::VCOUNT_W-1:0]  i_cfg_wdata,
    gbt_in_if.sink                        i_in,
    gbt_out_if.source                     o_out
);

    localparam int VW   = gbt_pkg::VERTEX_W;
    localparam int LW   = gbt_pkg::LIMIT_W;
    // Vertex index, list count and queue/stack pointer widths.
    localparam int VIW  = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_DEGREE + 1);
    localparam int QW   = $clog2(MAX_VERTICES + 1);
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int SAW  = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int WMW  = VW + CW;

    // Registers.
    gbt_pkg::t_state        r_state, n_state;
    logic [gbt_pkg::VCOUNT_W-1:0] r_vcount;
    logic [CW-1:0]          r_count [0:MAX_VERTICES-1];
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [VW-1:0]          r_a, n_a, r_b, n_b;
    logic [VW-1:0]          r_cur, n_cur;
    logic [CW-1:0]          r_pos, n_pos;
    logic [QW-1:0]          r_head, n_head, r_tail, n_tail, r_depth, n_depth;
    logic                   r_pend_ok, n_pend_ok;
    logic [VW-1:0]          r_pend_v, n_pend_v;
    logic                   r_o_valid;
    gbt_pkg::t_out_item     r_o_data;

    // Memories: neighbor lists, and the walk queue or stack (never both at once).
    logic [VW-1:0]          r_nbr_mem [0:MAX_VERTICES*MAX_DEGREE-1];
    logic [VW-1:0]          r_nbr_rd;
    logic [WMW-1:0]         r_walk_mem [0:MAX_VERTICES-1];
    logic [WMW-1:0]         r_walk_rd;

    // Combinational controls.
    logic                   out_free, in_fire;
    logic [LW-1:0]          vlimit;
    logic [VIW-1:0]         cidx;
    logic [CW-1:0]          cnt_rd;
    logic                   cnt_we, cnt_clr;
    logic [VIW-1:0]         cnt_widx;
    logic [CW-1:0]          cnt_wdata;
    logic                   nbr_we, nbr_re;
    logic [SAW-1:0]         nbr_waddr, nbr_raddr;
    logic [VW-1:0]          nbr_wdata;
    logic                   walk_we, walk_re;
    logic [AW-1:0]          walk_waddr, walk_raddr;
    logic [WMW-1:0]         walk_wdata;
    logic                   o_ld;
    gbt_pkg::t_out_item     o_next;
    logic [VW-1:0]          wr_vtx;
    logic [CW-1:0]          wr_pos;
    logic [QW-1:0]          depth_m1;
    logic                   nb_new;

    // The vertex limit is the register value capped at the table size.
    assign vlimit = (LW'(r_vcount) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(r_vcount);

    // A result beat may be loaded when the output register is empty or draining.
    assign out_free    = !r_o_valid || o_out.ready;
    assign i_in.ready  = (r_state == gbt_pkg::ST_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_data;

    // Single read port on the count registers.
    assign cnt_rd   = r_count[cidx];
    assign wr_vtx   = r_walk_rd[WMW-1:CW];
    assign wr_pos   = r_walk_rd[CW-1:0];
    assign depth_m1 = r_depth - QW'(1);

    // A neighbor is taken when it is inside the limit and not yet marked.
    assign nb_new = (LW'(r_nbr_rd) < vlimit) && !r_visited[VIW'(r_nbr_rd)];

    always_comb begin
        n_state   = r_state;
        n_visited = r_visited;
        n_a       = r_a;
        n_b       = r_b;
        n_cur     = r_cur;
        n_pos     = r_pos;
        n_head    = r_head;
        n_tail    = r_tail;
        n_depth   = r_depth;
        n_pend_ok = r_pend_ok;
        n_pend_v  = r_pend_v;
        cidx      = VIW'(i_in.data.start_vertex);
        cnt_we    = 1'b0;
        cnt_clr   = 1'b0;
        cnt_widx  = '0;
        cnt_wdata = '0;
        nbr_we    = 1'b0;
        nbr_re    = 1'b0;
        nbr_waddr = '0;
        nbr_raddr = '0;
        nbr_wdata = '0;
        walk_we   = 1'b0;
        walk_re   = 1'b0;
        walk_waddr = '0;
        walk_raddr = '0;
        walk_wdata = '0;
        o_ld      = 1'b0;
        o_next    = '{kind: gbt_pkg::KIND_ACK, vertex: '0, last: 1'b1};

        case (r_state)
            gbt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_a = i_in.data.from_vertex;
                    n_b = i_in.data.to_vertex;
                    case (i_in.data.cmd)
                        gbt_pkg::CMD_CLEAR: begin
                            cnt_clr = 1'b1;
                            o_ld    = 1'b1;
                        end
                        gbt_pkg::CMD_EDGE: begin
                            if (LW'(i_in.data.from_vertex) >= vlimit ||
                                LW'(i_in.data.to_vertex) >= vlimit) begin
                                o_ld        = 1'b1;
                                o_next.kind = gbt_pkg::KIND_ERROR;
                            end else begin
                                n_state = gbt_pkg::ST_E_A;
                            end
                        end
                        default: begin
                            if (LW'(i_in.data.start_vertex) >= vlimit) begin
                                o_ld        = 1'b1;
                                o_next.kind = gbt_pkg::KIND_ERROR;
                            end else begin
                                n_visited = '0;
                                n_visited[VIW'(i_in.data.start_vertex)] = 1'b1;
                                walk_we    = 1'b1;
                                walk_waddr = '0;
                                if (i_in.data.cmd == gbt_pkg::CMD_BFS) begin
                                    walk_wdata = {i_in.data.start_vertex, CW'(0)};
                                    n_head     = '0;
                                    n_tail     = QW'(1);
                                    n_pend_ok  = 1'b0;
                                    n_state    = gbt_pkg::ST_B_POP;
                                end else begin
                                    // The start vertex is visited at once and held back
                                    // until it is known whether it is the final one.
                                    walk_wdata = {i_in.data.start_vertex, cnt_rd};
                                    n_depth    = QW'(1);
                                    n_pend_ok  = 1'b1;
                                    n_pend_v   = i_in.data.start_vertex;
                                    n_state    = gbt_pkg::ST_D_TOP;
                                end
                            end
                        end
                    endcase
                end
            end

            // Add-edge: check both lists, then write one entry per cycle unless stalled.
            gbt_pkg::ST_E_A: begin
                cidx = VIW'(r_a);
                if ((r_a == r_b) ? ((CW+1)'(cnt_rd) + (CW+1)'(2) > (CW+1)'(MAX_DEGREE))
                                 : (cnt_rd >= CW'(MAX_DEGREE))) begin
                    if (out_free) begin
                        o_ld        = 1'b1;
                        o_next.kind = gbt_pkg::KIND_ERROR;
                        n_state     = gbt_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = gbt_pkg::ST_E_B;
                end
            end
            gbt_pkg::ST_E_B: begin
                cidx = VIW'(r_b);
                if (r_a != r_b && cnt_rd >= CW'(MAX_DEGREE)) begin
                    if (out_free) begin
                        o_ld        = 1'b1;
                        o_next.kind = gbt_pkg::KIND_ERROR;
                        n_state     = gbt_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = gbt_pkg::ST_E_W1;
                end
            end
            gbt_pkg::ST_E_W1: begin
                cidx      = VIW'(r_a);
                nbr_we    = 1'b1;
                nbr_waddr = SAW'(r_a) * SAW'(MAX_DEGREE) + SAW'(cnt_rd);
                nbr_wdata = r_b;
                cnt_we    = 1'b1;
                cnt_widx  = VIW'(r_a);
                cnt_wdata = cnt_rd + CW'(1);
                n_state   = gbt_pkg::ST_E_W2;
            end
            gbt_pkg::ST_E_W2: begin
                // For a self-loop the count read here already includes the first entry.
                cidx = VIW'(r_b);
                if (out_free) begin
                    nbr_we    = 1'b1;
                    nbr_waddr = SAW'(r_b) * SAW'(MAX_DEGREE) + SAW'(cnt_rd);
                    nbr_wdata = r_a;
                    cnt_we    = 1'b1;
                    cnt_widx  = VIW'(r_b);
                    cnt_wdata = cnt_rd + CW'(1);
                    o_ld      = 1'b1;
                    n_state   = gbt_pkg::ST_IDLE;
                end
            end

            // Breadth-first walk.
            gbt_pkg::ST_B_POP: begin
                if (r_head == r_tail) begin
                    n_state = gbt_pkg::ST_END;
                end else begin
                    walk_re    = 1'b1;
                    walk_raddr = r_head[AW-1:0];
                    n_head     = r_head + QW'(1);
                    n_state    = gbt_pkg::ST_B_CUR;
                end
            end
            gbt_pkg::ST_B_CUR: begin
                cidx = VIW'(wr_vtx);
                if (!r_pend_ok || out_free) begin
                    if (r_pend_ok) begin
                        o_ld          = 1'b1;
                        o_next.kind   = gbt_pkg::KIND_VISIT;
                        o_next.vertex = r_pend_v;
                        o_next.last   = 1'b0;
                    end
                    n_pend_ok = 1'b1;
                    n_pend_v  = wr_vtx;
                    n_cur     = wr_vtx;
                    n_pos     = cnt_rd;
                    n_state   = gbt_pkg::ST_B_NRD;
                end
            end
            gbt_pkg::ST_B_NRD: begin
                if (r_pos == '0) begin
                    n_state = gbt_pkg::ST_B_POP;
                end else begin
                    n_pos     = r_pos - CW'(1);
                    nbr_re    = 1'b1;
                    nbr_raddr = SAW'(r_cur) * SAW'(MAX_DEGREE) + SAW'(r_pos - CW'(1));
                    n_state   = gbt_pkg::ST_B_NCHK;
                end
            end
            gbt_pkg::ST_B_NCHK: begin
                if (nb_new && r_tail < QW'(MAX_VERTICES)) begin
                    n_visited[VIW'(r_nbr_rd)] = 1'b1;
                    walk_we    = 1'b1;
                    walk_waddr = r_tail[AW-1:0];
                    walk_wdata = {r_nbr_rd, CW'(0)};
                    n_tail     = r_tail + QW'(1);
                end
                n_state = gbt_pkg::ST_B_NRD;
            end

            // Depth-first walk over a stack of (vertex, list position) entries.
            gbt_pkg::ST_D_TOP: begin
                if (r_depth == '0) begin
                    n_state = gbt_pkg::ST_END;
                end else begin
                    walk_re    = 1'b1;
                    walk_raddr = depth_m1[AW-1:0];
                    n_state    = gbt_pkg::ST_D_GOT;
                end
            end
            gbt_pkg::ST_D_GOT: begin
                if (wr_pos == '0) begin
                    n_depth = depth_m1;
                    n_state = gbt_pkg::ST_D_TOP;
                end else begin
                    walk_we    = 1'b1;
                    walk_waddr = depth_m1[AW-1:0];
                    walk_wdata = {wr_vtx, wr_pos - CW'(1)};
                    nbr_re     = 1'b1;
                    nbr_raddr  = SAW'(wr_vtx) * SAW'(MAX_DEGREE) + SAW'(wr_pos - CW'(1));
                    n_cur      = wr_vtx;
                    n_state    = gbt_pkg::ST_D_CHK;
                end
            end
            gbt_pkg::ST_D_CHK: begin
                cidx = VIW'(r_nbr_rd);
                if (nb_new && r_depth < QW'(MAX_VERTICES)) begin
                    if (out_free) begin
                        o_ld          = 1'b1;
                        o_next.kind   = gbt_pkg::KIND_VISIT;
                        o_next.vertex = r_pend_v;
                        o_next.last   = 1'b0;
                        n_pend_v      = r_nbr_rd;
                        n_visited[VIW'(r_nbr_rd)] = 1'b1;
                        walk_we    = 1'b1;
                        walk_waddr = r_depth[AW-1:0];
                        walk_wdata = {r_nbr_rd, cnt_rd};
                        n_depth    = r_depth + QW'(1);
                        n_state    = gbt_pkg::ST_D_TOP;
                    end
                end else begin
                    n_state = gbt_pkg::ST_D_TOP;
                end
            end

            // Release the held-back final visit with its last flag.
            gbt_pkg::ST_END: begin
                if (out_free) begin
                    o_ld          = 1'b1;
                    o_next.kind   = gbt_pkg::KIND_VISIT;
                    o_next.vertex = r_pend_v;
                    o_next.last   = 1'b1;
                    n_pend_ok     = 1'b0;
                    n_state       = gbt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gbt_pkg::ST_IDLE;
            r_vcount  <= gbt_pkg::VCOUNT_RESET;
            r_visited <= '0;
            r_pend_ok <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_pend_ok <= n_pend_ok;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_depth   <= n_depth;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (cnt_clr) begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    r_count[i] <= '0;
                end
            end else if (cnt_we) begin
                r_count[cnt_widx] <= cnt_wdata;
            end
            if (o_ld) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_pos    <= n_pos;
        r_pend_v <= n_pend_v;
        if (o_ld) begin
            r_o_data <= o_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nbr_we) begin
            r_nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        if (nbr_re) begin
            r_nbr_rd <= r_nbr_mem[nbr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_we) begin
            r_walk_mem[walk_waddr] <= walk_wdata;
        end
        if (walk_re) begin
            r_walk_rd <= r_walk_mem[walk_raddr];
        end
    end

    `GBT_ASSERT_SAME(a_walk_bounds, i_clk, i_rst_n, 1'b1, (r_head <= r_tail && r_tail <= QW'(MAX_VERTICES) && r_depth <= QW'(MAX_VERTICES)), "walk pointer out of range")
    `GBT_ASSERT_SAME(a_visit_in_range, i_clk, i_rst_n, (r_o_valid && r_o_data.kind == gbt_pkg::KIND_VISIT), (LW'(r_o_data.vertex) < vlimit), "visited vertex beyond limit")
    `GBT_ASSERT_SAME(a_single_last, i_clk, i_rst_n, (r_o_valid && r_o_data.kind != gbt_pkg::KIND_VISIT), r_o_data.last, "ack or error beat without last")
    `GBT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_fire, (r_o_valid || r_state != gbt_pkg::ST_IDLE), "accepted beat produced no work")

endmodule

// File: dv/tb_graph_bfs_dfs_traversal.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graph_bfs_dfs_traversal
// Self-checking regression for the graph traversal block. Command beats go in
// through the input channel. A software copy of the graph works out the result
// beats that each accepted command should give, and a checker process compares
// every result beat against the oldest one still waiting.
// ----------------------------------------------------------------------------
module tb_graph_bfs_dfs_traversal;

    localparam int NV = gbt_pkg::DEF_MAX_VERTICES;
    localparam int ND = gbt_pkg::DEF_MAX_DEGREE;
    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [gbt_pkg::VCOUNT_W-1:0] i_cfg_wdata;

    gbt_in_if  cmd_ch ();
    gbt_out_if res_ch ();

    graph_bfs_dfs_traversal DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (cmd_ch),
        .o_out      (res_ch)
    );

    // Graph copy kept in step with the block.
    logic [gbt_pkg::VERTEX_W-1:0] adj_list [NV][ND];
    int                  adj_len  [NV];
    bit                  seen     [NV];
    logic [gbt_pkg::VCOUNT_W-1:0] vcount_reg;

    gbt_pkg::t_out_item expected_beats [$];
    int  error_count;
    longint cycle_count;
    bit  idle_enable;     // random gaps on both sides
    int  sink_holdoff;    // long receiver stall, counted down by the sink
    int  i;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("graph_bfs_dfs_traversal regression: fail");
                $finish;
            end
        end
    end

    function automatic int vlimit();
        return (vcount_reg > NV) ? NV : int'(vcount_reg);
    endfunction

    function automatic void push_beat(logic [gbt_pkg::KIND_W-1:0] k,
                                      logic [gbt_pkg::VERTEX_W-1:0] v, logic l);
        gbt_pkg::t_out_item b;
        b.kind = k;
        b.vertex = v;
        b.last = l;
        expected_beats.push_back(b);
    endfunction

    // Works out the result beats of one accepted command and updates the graph.
    function automatic void predict_command(gbt_pkg::t_in_item c);
        int lim;
        int a;
        int b;
        int q [$];
        int stk_v [$];
        int stk_p [$];
        int cur;
        int nb;
        int p;
        int first;
        lim = vlimit();
        a = c.from_vertex;
        b = c.to_vertex;
        if (c.cmd == gbt_pkg::CMD_CLEAR) begin
            foreach (adj_len[k]) adj_len[k] = 0;
            push_beat(gbt_pkg::KIND_ACK, '0, 1'b1);
            return;
        end
        if (c.cmd == gbt_pkg::CMD_EDGE) begin
            if (a >= lim || b >= lim ||
                (a == b && adj_len[a] + 2 > ND) ||
                (a != b && (adj_len[a] >= ND || adj_len[b] >= ND))) begin
                push_beat(gbt_pkg::KIND_ERROR, '0, 1'b1);
                return;
            end
            adj_list[a][adj_len[a]] = b[gbt_pkg::VERTEX_W-1:0];
            adj_len[a]++;
            adj_list[b][adj_len[b]] = a[gbt_pkg::VERTEX_W-1:0];
            adj_len[b]++;
            push_beat(gbt_pkg::KIND_ACK, '0, 1'b1);
            return;
        end
        if (c.start_vertex >= lim) begin
            push_beat(gbt_pkg::KIND_ERROR, '0, 1'b1);
            return;
        end
        foreach (seen[k]) seen[k] = 1'b0;
        first = expected_beats.size();
        seen[c.start_vertex] = 1'b1;
        if (c.cmd == gbt_pkg::CMD_BFS) begin
            q.push_back(c.start_vertex);
            while (q.size() > 0) begin
                cur = q.pop_front();
                push_beat(gbt_pkg::KIND_VISIT, cur[gbt_pkg::VERTEX_W-1:0], 1'b0);
                // Newest neighbor first.
                for (p = adj_len[cur] - 1; p >= 0; p--) begin
                    nb = adj_list[cur][p];
                    if (nb < lim && !seen[nb]) begin
                        seen[nb] = 1'b1;
                        q.push_back(nb);
                    end
                end
            end
        end else begin
            push_beat(gbt_pkg::KIND_VISIT, c.start_vertex, 1'b0);
            stk_v.push_back(c.start_vertex);
            stk_p.push_back(adj_len[c.start_vertex]);
            while (stk_v.size() > 0) begin
                if (stk_p[$] == 0) begin
                    void'(stk_v.pop_back());
                    void'(stk_p.pop_back());
                end else begin
                    stk_p[$] = stk_p[$] - 1;
                    nb = adj_list[stk_v[$]][stk_p[$]];
                    if (nb < lim && !seen[nb] && stk_v.size() < NV) begin
                        seen[nb] = 1'b1;
                        push_beat(gbt_pkg::KIND_VISIT, nb[gbt_pkg::VERTEX_W-1:0], 1'b0);
                        stk_v.push_back(nb);
                        stk_p.push_back(adj_len[nb]);
                    end
                end
            end
        end
        expected_beats[expected_beats.size() - 1].last = 1'b1;
        if (first < 0) return;
    endfunction

    // Result checker: a beat is taken at a rising edge with valid and ready high.
    initial begin
        gbt_pkg::t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, res_ch.data);
                    error_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (res_ch.data.kind !== want.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                                 res_ch.data.kind);
                        error_count++;
                    end
                    if (res_ch.data.vertex !== want.vertex) begin
                        $display("%0t: vertex expected %0d actual %0d", $time,
                                 want.vertex, res_ch.data.vertex);
                        error_count++;
                    end
                    if (res_ch.data.last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d", $time, want.last,
                                 res_ch.data.last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver: ready changes at the falling edge; random stall bursts and
    // an optional long hold-off.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_holdoff > 0) begin
                sink_holdoff--;
                res_ch.ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 11);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Sends one command beat; the prediction is made when it is accepted.
    // Valid stays high after the accepting edge until the next falling edge,
    // where either the next beat replaces it or it is dropped.
    task automatic send_command(gbt_pkg::t_in_item c);
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_command(c);
    endtask

    task automatic send_fields(logic [gbt_pkg::CMD_W-1:0] c, int a, int b, int s);
        gbt_pkg::t_in_item it;
        it.cmd = c;
        it.from_vertex = a[gbt_pkg::VERTEX_W-1:0];
        it.to_vertex = b[gbt_pkg::VERTEX_W-1:0];
        it.start_vertex = s[gbt_pkg::VERTEX_W-1:0];
        send_command(it);
    endtask

    // Drops valid, then waits until every expected beat has come plus the
    // block's tail latency.
    task automatic drain();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (expected_beats.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Vertex count is written only with the block idle.
    task automatic write_vertex_count(int n);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n[gbt_pkg::VCOUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        vcount_reg = n[gbt_pkg::VCOUNT_W-1:0];
    endtask

    // Random command, mostly well-formed edges and walks in range.
    task automatic send_random(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) send_fields(gbt_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
        else if (r < 55)
            send_fields(gbt_pkg::CMD_EDGE, $urandom_range(0, span - 1),
                        $urandom_range(0, span - 1), $urandom);
        else if (r < 62) send_fields(gbt_pkg::CMD_EDGE, $urandom, $urandom, $urandom);
        else send_fields(r < 81 ? gbt_pkg::CMD_BFS : gbt_pkg::CMD_DFS, $urandom, $urandom,
                         $urandom_range(0, span - 1) | ($urandom_range(0, 9) == 0 ? 16 : 0));
    endtask

    task automatic test_directed();
        send_fields(gbt_pkg::CMD_BFS, 0, 0, 0);          // lone vertex walk
        send_fields(gbt_pkg::CMD_DFS, 31, 31, 31);
        send_fields(gbt_pkg::CMD_EDGE, 0, 31, 0);
        send_fields(gbt_pkg::CMD_EDGE, 31, 0, 21);
        send_fields(gbt_pkg::CMD_EDGE, 5, 5, 10);        // self-loop adds two entries
        send_fields(gbt_pkg::CMD_EDGE, 0, 5, 0);
        send_fields(gbt_pkg::CMD_EDGE, 5, 10, 0);
        send_fields(gbt_pkg::CMD_EDGE, 10, 21, 0);
        send_fields(gbt_pkg::CMD_BFS, 0, 0, 0);
        send_fields(gbt_pkg::CMD_DFS, 0, 0, 0);
        send_fields(gbt_pkg::CMD_DFS, 0, 0, 21);
        send_fields(gbt_pkg::CMD_CLEAR, 31, 31, 31);
        send_fields(gbt_pkg::CMD_DFS, 0, 0, 0);
        write_vertex_count(0);                           // every index rejected
        send_fields(gbt_pkg::CMD_EDGE, 0, 0, 0);
        send_fields(gbt_pkg::CMD_BFS, 0, 0, 0);
        write_vertex_count(63);                          // acts as the full vertex range
        send_fields(gbt_pkg::CMD_EDGE, 31, 30, 0);
        write_vertex_count(20);
        send_fields(gbt_pkg::CMD_EDGE, 19, 20, 0);       // bad endpoint
        send_fields(gbt_pkg::CMD_DFS, 0, 0, 20);         // bad start
        send_fields(gbt_pkg::CMD_BFS, 0, 0, 10);         // lone vertex walk after the clear
    endtask

    // Fills one neighbor list to its limit, then overflows it.
    task automatic test_full_list();
        write_vertex_count(32);
        send_fields(gbt_pkg::CMD_CLEAR, 0, 0, 0);
        for (int k = 0; k < 15; k++) send_fields(gbt_pkg::CMD_EDGE, 3, 3, 0);
        send_fields(gbt_pkg::CMD_EDGE, 3, 3, 0);         // exactly full
        send_fields(gbt_pkg::CMD_EDGE, 3, 3, 0);         // no room for two
        send_fields(gbt_pkg::CMD_EDGE, 3, 4, 0);
        send_fields(gbt_pkg::CMD_EDGE, 4, 3, 0);
        send_fields(gbt_pkg::CMD_CLEAR, 0, 0, 0);
        for (int k = 0; k < 31; k++) send_fields(gbt_pkg::CMD_EDGE, 7, k + (k >= 7), 0);
        send_fields(gbt_pkg::CMD_EDGE, 7, 7, 0);         // one slot left, self-loop needs two
        send_fields(gbt_pkg::CMD_EDGE, 7, 7 + 0, 0);
        send_fields(gbt_pkg::CMD_BFS, 0, 0, 7);
        send_fields(gbt_pkg::CMD_DFS, 0, 0, 7);
    endtask

    // Random phases over several vertex counts.
    task automatic test_random_walks();
        int counts [4];
        counts = '{1, 8, 32, 17};
        foreach (counts[k]) begin
            write_vertex_count(counts[k]);
            send_fields(gbt_pkg::CMD_CLEAR, 0, 0, 0);
            for (int j = 0; j < 30; j++) send_random(counts[k] < 2 ? 2 : counts[k]);
        end
    endtask

    // Receiver holds off while commands keep coming, then the sender waits
    // for all results before going on.
    task automatic test_backpressure();
        write_vertex_count(12);
        send_fields(gbt_pkg::CMD_CLEAR, 0, 0, 0);
        drain();
        sink_holdoff = 300;
        for (int j = 0; j < 12; j++) send_random(12);
        drain();
    endtask

    initial begin
        error_count = 0;
        idle_enable = 1'b1;
        sink_holdoff = 0;
        vcount_reg = gbt_pkg::VCOUNT_RESET;
        foreach (adj_len[k]) adj_len[k] = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_full_list();
        test_backpressure();
        test_random_walks();
        // Closing stretch without any idling.
        idle_enable = 1'b0;
        write_vertex_count(32);
        for (i = 0; i < 30; i++) send_random(32);
        drain();

        if (error_count == 0) begin
            $display("graph_bfs_dfs_traversal regression: pass");
        end else begin
            $display("graph_bfs_dfs_traversal regression: fail");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+src
src/gbt_pkg.sv
src/gbt_if.sv
src/graph_bfs_dfs_traversal.sv
dv/tb_graph_bfs_dfs_traversal.sv
